FILE: rtl/chacha_pkg.sv
// Shared types, constants and helper functions for the ChaCha20 stream cipher.
`timescale 1ns / 1ps

package chacha_pkg;

  // Block function constants ("expand 32-byte k").
  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  localparam int unsigned DoubleRounds = 10;
  localparam int unsigned NumRounds    = 2 * DoubleRounds;
  localparam int unsigned RoundW       = $clog2(NumRounds);
  localparam logic [RoundW-1:0] LAST_ROUND = RoundW'(NumRounds - 1);

  // Quarter-round rotation amounts.
  localparam int unsigned ROT_A = 16;
  localparam int unsigned ROT_B = 12;
  localparam int unsigned ROT_C = 8;
  localparam int unsigned ROT_D = 7;

  // Quarter-round sub-step codes.
  localparam logic [1:0] SUB_AD16 = 2'd0;
  localparam logic [1:0] SUB_CB12 = 2'd1;
  localparam logic [1:0] SUB_AD8  = 2'd2;
  localparam logic [1:0] SUB_CB7  = 2'd3;

  // Configuration register indexes (byte address = 8 * index).
  localparam int unsigned PADDR_W = 6;
  localparam logic [2:0] REG_KEY01   = 3'd0;
  localparam logic [2:0] REG_KEY23   = 3'd1;
  localparam logic [2:0] REG_KEY45   = 3'd2;
  localparam logic [2:0] REG_KEY67   = 3'd3;
  localparam logic [2:0] REG_NONCE01 = 3'd4;
  localparam logic [2:0] REG_NONCE2  = 3'd5;
  localparam logic [2:0] REG_CTR     = 3'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] result_byte;
    logic       final_out;
  } out_item_t;

  typedef struct packed {
    logic [63:0] key_words_0_1;
    logic [63:0] key_words_2_3;
    logic [63:0] key_words_4_5;
    logic [63:0] key_words_6_7;
    logic [63:0] nonce_words_0_1;
    logic [31:0] nonce_word_2;
    logic [31:0] initial_counter;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept;  // latch the incoming transaction
    logic       load;    // start a new keystream block
    logic       step;    // one quarter-round sub-step on all four lanes
    logic       diag;    // diagonal round when set, column round otherwise
    logic [1:0] sub;     // sub-step code
    logic       feed;    // feed-forward addition into the keystream store
    logic       emit;    // write the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_block;
  } status_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

endpackage

FILE: rtl/chacha20_stream_cipher.sv
// ChaCha20 stream cipher: byte in, keystream-XORed byte out.
// Each accepted byte is held, then XORed with a keystream byte into the output register;
// a new 64-byte block is made first when needed (80 quarter-round sub-steps + feed-forward).
// A new byte is taken only once the last result is written, which waits on a stalled output;
// each sub-step covers all four lanes at once. Reset clears configuration and
// message state; the keystream store holds no value until the first block is made.
`timescale 1ns / 1ps

module chacha20_stream_cipher
  import chacha_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_data_o
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t sts;

  chacha_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  chacha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  chacha_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

FILE: rtl/chacha_regs.sv
// APB configuration register file for the ChaCha20 stream cipher.
`timescale 1ns / 1ps

module chacha_regs
  import chacha_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[PADDR_W-1:3];
  assign cfg_o   = cfg_q;

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_KEY01:   cfg_q.key_words_0_1   <= pwdata;
        REG_KEY23:   cfg_q.key_words_2_3   <= pwdata;
        REG_KEY45:   cfg_q.key_words_4_5   <= pwdata;
        REG_KEY67:   cfg_q.key_words_6_7   <= pwdata;
        REG_NONCE01: cfg_q.nonce_words_0_1 <= pwdata;
        REG_NONCE2:  cfg_q.nonce_word_2    <= pwdata[31:0];
        REG_CTR:     cfg_q.initial_counter <= pwdata[31:0];
        default:     ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    case (reg_idx)
      REG_KEY01:   prdata = cfg_q.key_words_0_1;
      REG_KEY23:   prdata = cfg_q.key_words_2_3;
      REG_KEY45:   prdata = cfg_q.key_words_4_5;
      REG_KEY67:   prdata = cfg_q.key_words_6_7;
      REG_NONCE01: prdata = cfg_q.nonce_words_0_1;
      REG_NONCE2:  prdata = {32'd0, cfg_q.nonce_word_2};
      REG_CTR:     prdata = {32'd0, cfg_q.initial_counter};
      default:     prdata = '0;
    endcase
  end

endmodule

FILE: rtl/chacha_ctrl.sv
// Controller state machine that sequences rounds and byte output for ChaCha20.
`timescale 1ns / 1ps

module chacha_ctrl
  import chacha_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t sts_i,
  output cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FEED,
    ST_EMIT
  } state_e;

  state_e            state_q;
  logic [RoundW-1:0] rnd_q;
  logic [1:0]        sub_q;
  logic              out_valid_q;
  logic              out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = ~out_valid_q | out_ready_i;

  // Command decode from the current state.
  always_comb begin
    cmd_o        = '0;
    cmd_o.accept = in_valid_i & (state_q == ST_IDLE);
    cmd_o.load   = cmd_o.accept & sts_i.need_block;
    cmd_o.step   = (state_q == ST_ROUND);
    cmd_o.diag   = rnd_q[0];
    cmd_o.sub    = sub_q;
    cmd_o.feed   = (state_q == ST_FEED);
    cmd_o.emit   = (state_q == ST_EMIT) & out_free;
  end

  // State, round counters and output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rnd_q       <= '0;
      sub_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.accept) begin
            rnd_q   <= '0;
            sub_q   <= '0;
            state_q <= sts_i.need_block ? ST_ROUND : ST_EMIT;
          end
        end
        ST_ROUND: begin
          sub_q <= sub_q + 2'd1;
          if (sub_q == SUB_CB7) begin
            rnd_q <= rnd_q + RoundW'(1);
            if (rnd_q == LAST_ROUND) begin
              state_q <= ST_FEED;
            end
          end
        end
        ST_FEED: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/chacha_datapath.sv
// ChaCha20 datapath: working state, keystream store, counters and output register.
`timescale 1ns / 1ps

module chacha_datapath
  import chacha_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  in_item_t  in_data_i,
  input  cmd_t      cmd_i,
  output status_t   sts_o,
  output out_item_t out_data_o
);

  logic [31:0] w_q  [16];
  logic [31:0] w_d  [16];
  logic [31:0] ks_q [16];
  logic [31:0] init_w [16];
  logic [31:0] counter_q;
  logic [31:0] ctr_word;
  logic [5:0]  pos_q;
  logic        in_msg_q;
  in_item_t    hold_q;
  out_item_t   out_q;
  logic [31:0] ks_word;
  logic [7:0]  ks_byte;

  assign sts_o.need_block = ~in_msg_q | (pos_q == 6'd0);
  assign out_data_o       = out_q;

  // A new message restarts from the configured counter.
  assign ctr_word = in_msg_q ? counter_q : cfg_i.initial_counter;

  // Input block; the counter word comes from the running counter once loaded.
  always_comb begin
    init_w[0]  = SIGMA0;
    init_w[1]  = SIGMA1;
    init_w[2]  = SIGMA2;
    init_w[3]  = SIGMA3;
    init_w[4]  = cfg_i.key_words_0_1[31:0];
    init_w[5]  = cfg_i.key_words_0_1[63:32];
    init_w[6]  = cfg_i.key_words_2_3[31:0];
    init_w[7]  = cfg_i.key_words_2_3[63:32];
    init_w[8]  = cfg_i.key_words_4_5[31:0];
    init_w[9]  = cfg_i.key_words_4_5[63:32];
    init_w[10] = cfg_i.key_words_6_7[31:0];
    init_w[11] = cfg_i.key_words_6_7[63:32];
    init_w[12] = cmd_i.load ? ctr_word : counter_q;
    init_w[13] = cfg_i.nonce_words_0_1[31:0];
    init_w[14] = cfg_i.nonce_words_0_1[63:32];
    init_w[15] = cfg_i.nonce_word_2;
  end

  // One quarter-round sub-step on all four lanes: x += y; z = (z ^ x) <<< r.
  always_comb begin
    logic [3:0]  ia, ib, ic, id;
    logic [31:0] sum;
    w_d = w_q;
    for (int q = 0; q < 4; q++) begin
      ia = 4'(q);
      ib = cmd_i.diag ? 4'(4 + ((q + 1) % 4))  : 4'(4 + q);
      ic = cmd_i.diag ? 4'(8 + ((q + 2) % 4))  : 4'(8 + q);
      id = cmd_i.diag ? 4'(12 + ((q + 3) % 4)) : 4'(12 + q);
      case (cmd_i.sub)
        SUB_AD16: begin
          sum       = w_q[ia] + w_q[ib];
          w_d[ia]   = sum;
          w_d[id]   = rotl(w_q[id] ^ sum, ROT_A);
        end
        SUB_CB12: begin
          sum       = w_q[ic] + w_q[id];
          w_d[ic]   = sum;
          w_d[ib]   = rotl(w_q[ib] ^ sum, ROT_B);
        end
        SUB_AD8: begin
          sum       = w_q[ia] + w_q[ib];
          w_d[ia]   = sum;
          w_d[id]   = rotl(w_q[id] ^ sum, ROT_C);
        end
        default: begin
          sum       = w_q[ic] + w_q[id];
          w_d[ic]   = sum;
          w_d[ib]   = rotl(w_q[ib] ^ sum, ROT_D);
        end
      endcase
    end
  end

  // Keystream byte, little-endian within each word.
  assign ks_word = ks_q[pos_q[5:2]];
  assign ks_byte = ks_word[{pos_q[1:0], 3'b000} +: 8];

  // Working state and keystream store.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      w_q <= init_w;
    end else if (cmd_i.step) begin
      w_q <= w_d;
    end
    if (cmd_i.feed) begin
      for (int i = 0; i < 16; i++) begin
        ks_q[i] <= w_q[i] + init_w[i];
      end
    end
    if (cmd_i.accept) begin
      hold_q <= in_data_i;
    end
    if (cmd_i.emit) begin
      out_q.result_byte <= hold_q.data_byte ^ ks_byte;
      out_q.final_out   <= hold_q.final_byte;
    end
  end

  // Counter, byte position and message flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q <= '0;
      pos_q     <= '0;
      in_msg_q  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        counter_q <= ctr_word;
        in_msg_q  <= 1'b1;
        if (!in_msg_q) begin
          pos_q <= '0;
        end
      end else if (cmd_i.feed) begin
        counter_q <= counter_q + 32'd1;
      end else if (cmd_i.emit) begin
        pos_q <= pos_q + 6'd1;
        if (hold_q.final_byte) begin
          in_msg_q <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the ChaCha20 byte-stream cipher.
`timescale 1ns / 1ps

module testbench
  import chacha_pkg::*;
();

  // Block function constants, kept locally for the keystream predictor.
  localparam logic [31:0] EXPAND_0 = 32'h61707865;
  localparam logic [31:0] EXPAND_1 = 32'h3320646e;
  localparam logic [31:0] EXPAND_2 = 32'h79622d32;
  localparam logic [31:0] EXPAND_3 = 32'h6b206574;
  localparam int unsigned DOUBLE_ROUND_COUNT = 10;

  // Register index past the end of the map; writes to it are dropped.
  localparam logic [2:0] REG_UNMAPPED = 3'd7;

  localparam int unsigned MAX_GAP      = 10;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned SETTLE_TIME  = 100;
  localparam int unsigned CYCLE_LIMIT  = 600000;

  typedef struct {
    in_item_t    item;
    int unsigned gap;
  } tx_entry_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [63:0]        pwdata      = '0;
  logic [63:0]        prdata;
  logic               pready;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  in_item_t           in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_item_t          out_data_o;

  // Pending byte transactions and results still owed by the block.
  tx_entry_t   tx_queue[$];
  out_item_t   cipher_results_q[$];
  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;
  int unsigned hold_requests = 0;

  // Register mirror.
  logic [63:0] key_reg [4]   = '{default: '0};
  logic [63:0] nonce01_reg   = '0;
  logic [31:0] nonce2_reg    = '0;
  logic [31:0] start_ctr_reg = '0;

  // Keystream predictor state.
  logic [31:0] ks_words  [16];
  logic [31:0] mix_state [16];
  logic [31:0] blk_ctr  = '0;
  logic [5:0]  blk_pos  = '0;
  logic        msg_open = 1'b0;

  chacha20_stream_cipher uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function logic [31:0] rol32(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // One quarter round on the working block.
  function void mix_quad(input int a, input int b, input int c, input int d);
    mix_state[a] = mix_state[a] + mix_state[b];
    mix_state[d] = rol32(mix_state[d] ^ mix_state[a], 16);
    mix_state[c] = mix_state[c] + mix_state[d];
    mix_state[b] = rol32(mix_state[b] ^ mix_state[c], 12);
    mix_state[a] = mix_state[a] + mix_state[b];
    mix_state[d] = rol32(mix_state[d] ^ mix_state[a], 8);
    mix_state[c] = mix_state[c] + mix_state[d];
    mix_state[b] = rol32(mix_state[b] ^ mix_state[c], 7);
  endfunction

  // Build the next 64-byte keystream block from the current registers.
  function void refill_keystream();
    logic [31:0] seed [16];
    int          r;
    int          i;
    seed[0] = EXPAND_0;
    seed[1] = EXPAND_1;
    seed[2] = EXPAND_2;
    seed[3] = EXPAND_3;
    for (i = 0; i < 4; i++) begin
      seed[4 + 2 * i] = key_reg[i][31:0];
      seed[5 + 2 * i] = key_reg[i][63:32];
    end
    seed[12] = blk_ctr;
    seed[13] = nonce01_reg[31:0];
    seed[14] = nonce01_reg[63:32];
    seed[15] = nonce2_reg;
    for (i = 0; i < 16; i++) mix_state[i] = seed[i];
    for (r = 0; r < DOUBLE_ROUND_COUNT; r++) begin
      mix_quad(0, 4, 8, 12);
      mix_quad(1, 5, 9, 13);
      mix_quad(2, 6, 10, 14);
      mix_quad(3, 7, 11, 15);
      mix_quad(0, 5, 10, 15);
      mix_quad(1, 6, 11, 12);
      mix_quad(2, 7, 8, 13);
      mix_quad(3, 4, 9, 14);
    end
    for (i = 0; i < 16; i++) ks_words[i] = mix_state[i] + seed[i];
  endfunction

  // Encrypt one byte: open a message if needed, refill on block boundaries.
  function out_item_t encrypt_byte(input in_item_t item);
    out_item_t  res;
    logic [7:0] pad;
    if (!msg_open) begin
      blk_ctr  = start_ctr_reg;
      blk_pos  = '0;
      msg_open = 1'b1;
    end
    if (blk_pos == 6'd0) begin
      refill_keystream();
      blk_ctr = blk_ctr + 32'd1;
    end
    pad = ks_words[blk_pos[5:2]][{blk_pos[1:0], 3'b000} +: 8];
    blk_pos = blk_pos + 6'd1;
    if (item.final_byte) msg_open = 1'b0;
    res.result_byte = item.data_byte ^ pad;
    res.final_out   = item.final_byte;
    return res;
  endfunction

  // Byte driver: waits the drawn gap, then holds each transaction until taken.
  always @(posedge clk_i or negedge rst_ni) begin : byte_driver
    tx_entry_t   entry;
    int unsigned tx_wait;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      tx_wait = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        cipher_results_q.push_back(encrypt_byte(in_data_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (tx_queue.size() != 0 && tx_queue[0].gap > tx_wait) begin
          tx_wait++;
          in_valid_i <= 1'b0;
        end else if (tx_queue.size() != 0) begin
          entry = tx_queue.pop_front();
          tx_wait = 0;
          in_valid_i <= 1'b1;
          in_data_i  <= entry.item;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure and an occasional long hold.
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    out_item_t   want;
    int unsigned rx_wait;
    int unsigned rx_gap_max;
    int unsigned hold_served;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_wait     = 0;
      rx_gap_max  = MAX_GAP;
      hold_served = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (cipher_results_q.size() == 0) begin
          $error("unexpected result transaction: result_byte %h final_out %b",
                 out_data_o.result_byte, out_data_o.final_out);
          error_count++;
        end else begin
          want = cipher_results_q.pop_front();
          if (out_data_o.result_byte !== want.result_byte) begin
            $error("result_byte mismatch: expected %h, actual %h",
                   want.result_byte, out_data_o.result_byte);
            error_count++;
          end
          if (out_data_o.final_out !== want.final_out) begin
            $error("final_out mismatch: expected %b, actual %b",
                   want.final_out, out_data_o.final_out);
            error_count++;
          end
        end
        // Switch now and then between stalling and always-ready stretches.
        if ($urandom_range(0, 49) == 0) rx_gap_max = (rx_gap_max == 0) ? MAX_GAP : 0;
        rx_wait = $urandom_range(0, rx_gap_max);
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        rx_wait     = LONG_HOLD;
      end
      if (rx_wait != 0) begin
        rx_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function void queue_byte(input logic [7:0] data, input logic last,
                           input int unsigned gap);
    tx_entry_t e;
    e.item.data_byte  = data;
    e.item.final_byte = last;
    e.gap             = gap;
    tx_queue.push_back(e);
  endfunction

  // One message of random bytes; returns how many bytes were queued.
  function int unsigned queue_message(input int unsigned len, input int unsigned limit,
                                      input int unsigned gap_max);
    int unsigned i;
    for (i = 0; i < len && i < limit; i++) begin
      queue_byte(8'($urandom_range(0, 255)), i == len - 1, $urandom_range(0, gap_max));
    end
    return i;
  endfunction

  // Random mix of short, block-sized and multi-block messages.
  function void queue_messages(input int unsigned count, input bit allow_gaps);
    int unsigned left;
    int unsigned len;
    int unsigned sel;
    int unsigned gap_max;
    left = count;
    while (left != 0) begin
      sel = $urandom_range(0, 9);
      if (sel < 4) len = $urandom_range(1, 8);
      else if (sel < 8) len = $urandom_range(9, 70);
      else len = $urandom_range(71, 200);
      gap_max = (allow_gaps && $urandom_range(0, 3) != 0) ? MAX_GAP : 0;
      left = left - queue_message(len, left, gap_max);
    end
  endfunction

  // APB write: setup cycle, then access cycle; mirror updated on completion.
  task automatic write_register(input logic [2:0] index, input logic [63:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (index)
      REG_KEY01:   key_reg[0]    = value;
      REG_KEY23:   key_reg[1]    = value;
      REG_KEY45:   key_reg[2]    = value;
      REG_KEY67:   key_reg[3]    = value;
      REG_NONCE01: nonce01_reg   = value;
      REG_NONCE2:  nonce2_reg    = value[31:0];
      REG_CTR:     start_ctr_reg = value[31:0];
      default: ;
    endcase
  endtask

  task automatic write_all_registers(input logic [63:0] k01, input logic [63:0] k23,
                                     input logic [63:0] k45, input logic [63:0] k67,
                                     input logic [63:0] n01, input logic [31:0] n2,
                                     input logic [31:0] ctr);
    write_register(REG_KEY01, k01);
    write_register(REG_KEY23, k23);
    write_register(REG_KEY45, k45);
    write_register(REG_KEY67, k67);
    write_register(REG_NONCE01, n01);
    write_register(REG_NONCE2, {32'h0, n2});
    write_register(REG_CTR, {32'h0, ctr});
  endtask

  // Sender pause: wait until every byte is taken and every result is back.
  task automatic wait_idle();
    while (tx_queue.size() != 0 || in_valid_i || cipher_results_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Test sequence.
  initial begin : stimulus
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration: short messages, a single-byte message, data extremes.
    queue_byte(8'h00, 1'b0, 0);
    queue_byte(8'hFF, 1'b0, 0);
    queue_byte(8'hA5, 1'b1, 0);
    queue_byte(8'h5A, 1'b1, 3);
    queue_byte(8'hFF, 1'b1, 0);
    queue_byte(8'h00, 1'b0, 1);
    wait_idle();

    // All-ones registers with the counter at its top value, so it wraps.
    write_all_registers('1, '1, '1, '1, '1, '1, '1);
    write_register(REG_UNMAPPED, {$urandom, $urandom});
    queue_byte(8'h00, 1'b1, 0);
    queue_byte(8'hFF, 1'b0, 0);
    queue_byte(8'h3C, 1'b1, 2);
    void'(queue_message(130, 130, MAX_GAP));
    queue_messages(120, 1'b1);
    wait_idle();

    // Random registers; long receiver hold while bytes keep coming.
    write_all_registers({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                        {$urandom, $urandom}, {$urandom, $urandom}, $urandom, $urandom);
    queue_messages(40, 1'b1);
    hold_requests <= hold_requests + 1;
    queue_messages(100, 1'b0);
    queue_messages(60, 1'b1);
    wait_idle();

    // All-zero key and nonce, counter just short of wrapping.
    write_all_registers('0, '0, '0, '0, '0, '0, 32'hFFFF_FFFE);
    void'(queue_message(140, 140, 0));
    queue_messages(110, 1'b1);
    wait_idle();

    // Further random settings.
    repeat (2) begin
      write_all_registers({$urandom, $urandom}, {$urandom, $urandom},
                          {$urandom, $urandom}, {$urandom, $urandom},
                          {$urandom, $urandom}, $urandom, $urandom);
      queue_messages(20, 1'b1);
      wait_idle();
    end

    repeat (SETTLE_TIME) @(posedge clk_i);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
